// ----- rtl/rbc_pkg.sv -----
// rbc_pkg: shared types and constants for the rotor byte cipher
// used by rotor_byte_cipher, rbc_swap_mem and rbc_checker; no dependencies
package rbc_pkg;

  localparam int unsigned KEY_N     = 32;
  localparam int unsigned ENTRY_W   = 5;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 60;
  localparam int unsigned PART2_W   = 40;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [TYPE_W-1:0] tctr_t;
  typedef logic [KEY_N-1:0][ENTRY_W-1:0] key_t;

  localparam entry_t LAST_ENTRY = entry_t'(KEY_N - 1);
  localparam entry_t ENTRY_MAX  = '1;
  localparam tctr_t  TYPE_MAX   = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_LOOK1,
    ST_LOOK2,
    ST_LOOK3
  } state_t;

  typedef struct packed {
    logic   en;
    entry_t addr;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    logic   en;
    entry_t addr;
  } mem_rd_t;

  // distance search over one pair of key values
  typedef struct packed {
    logic   found;
    logic   done;
    entry_t first;
    tctr_t  gap;
  } dist_trk_t;

endpackage

// ----- rtl/rbc_swap_mem.sv -----
// rbc_swap_mem: 32 x 5 swap table, one write port, one registered read port
// entries never written read as their own address; depends on rbc_pkg
module rbc_swap_mem (
  input  logic            clk,
  input  logic            rst,
  input  rbc_pkg::mem_wr_t wr,
  input  rbc_pkg::mem_rd_t rd,
  output rbc_pkg::entry_t  rd_data
);

  rbc_pkg::entry_t               mem [rbc_pkg::KEY_N];
  logic [rbc_pkg::KEY_N-1:0]     written;
  rbc_pkg::entry_t               q;
  rbc_pkg::entry_t               q_addr;
  logic                          q_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q      <= mem[rd.addr];
      q_addr <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      q_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        q_valid <= written[rd.addr];
      end
    end
  end

  // unwritten entry holds the identity mapping
  assign rd_data = q_valid ? q : q_addr;

endmodule

// ----- rtl/rotor_byte_cipher.sv -----
// rotor_byte_cipher: byte stream cipher with swap table and two 3-counter rotors
// depends on rbc_pkg and rbc_swap_mem
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   cfg     | cfg_we, cfg_index, cfg_data       | in, write only
//   byte    | byte_valid/byte_ready, restart,   | in
//           | data_in                           |
//   code    | code_valid/code_ready, data_out   | out
//
// an ordinary item passes ST_LOOK2 and ST_LOOK3 after its accept edge; the
// result is registered on leaving ST_LOOK3, and the next item is taken back in
// ST_IDLE, a pace set by two dependent reads through the swap table's read port
// a restart item adds ST_SWEEP and ST_LOOK1: the table rebuild writes one entry
// per cycle over all 32 key positions; the distance search shares the sweep
// one item is in work at a time; the result register lets the next item be
// accepted while a result still waits, and a full result register holds the
// item in its last cycle. reset restores the identity table and zero rotors
module rotor_byte_cipher (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rbc_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  byte_valid,
  output logic                                  byte_ready,
  input  logic                                  restart,
  input  logic [rbc_pkg::BYTE_W-1:0]            data_in,
  output logic                                  code_valid,
  input  logic                                  code_ready,
  output logic [rbc_pkg::BYTE_W-1:0]            data_out
);

  logic [rbc_pkg::CFG_W-1:0]   key_part0;
  logic [rbc_pkg::CFG_W-1:0]   key_part1;
  logic [rbc_pkg::PART2_W-1:0] key_part2;
  rbc_pkg::key_t               keys;

  rbc_pkg::state_t             state, state_next;
  rbc_pkg::entry_t             cnt;
  logic [rbc_pkg::BYTE_W-1:0]  x_q;
  rbc_pkg::dist_trk_t          trk [3];
  rbc_pkg::dist_trk_t          trk_next [3];
  rbc_pkg::entry_t             vctr [3];
  rbc_pkg::entry_t             vctr_next [3];
  rbc_pkg::tctr_t              tctr [3];
  rbc_pkg::tctr_t              tctr_next [3];
  rbc_pkg::entry_t             vidx;
  rbc_pkg::tctr_t              tidx;
  rbc_pkg::entry_t             sweep_entry;
  rbc_pkg::mem_wr_t            mem_wr;
  rbc_pkg::mem_rd_t            mem_rd;
  rbc_pkg::entry_t             rd_data;
  logic                        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_part0 <= '0;
      key_part1 <= '0;
      key_part2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbc_pkg::REG_KEY0: key_part0 <= cfg_data;
        rbc_pkg::REG_KEY1: key_part1 <= cfg_data;
        rbc_pkg::REG_KEY2: key_part2 <= cfg_data[rbc_pkg::PART2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign keys = {key_part2, key_part1, key_part0};

  assign vidx = rbc_pkg::entry_t'(vctr[0] + vctr[1] + vctr[2]);
  assign tidx = rbc_pkg::tctr_t'(tctr[0] + tctr[1] + tctr[2]);
  assign sweep_entry = keys[cnt];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rbc_pkg::ST_IDLE: begin
        if (byte_valid) begin
          state_next = restart ? rbc_pkg::ST_SWEEP : rbc_pkg::ST_LOOK2;
        end
      end
      rbc_pkg::ST_SWEEP: begin
        if (cnt == rbc_pkg::LAST_ENTRY) begin
          state_next = rbc_pkg::ST_LOOK1;
        end
      end
      rbc_pkg::ST_LOOK1: state_next = rbc_pkg::ST_LOOK2;
      rbc_pkg::ST_LOOK2: state_next = rbc_pkg::ST_LOOK3;
      rbc_pkg::ST_LOOK3: begin
        if (!code_valid || code_ready) begin
          state_next = rbc_pkg::ST_IDLE;
        end
      end
      default: state_next = rbc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    byte_ready   = 1'b0;
    fire         = 1'b0;
    mem_rd.en    = 1'b0;
    mem_rd.addr  = data_in[rbc_pkg::ENTRY_W-1:0];
    mem_wr.en    = 1'b0;
    mem_wr.addr  = sweep_entry;
    mem_wr.data  = keys[rbc_pkg::LAST_ENTRY - cnt];
    unique case (state)
      rbc_pkg::ST_IDLE: begin
        byte_ready = 1'b1;
        // plain item: first lookup starts on the accept edge
        mem_rd.en  = byte_valid && !restart;
      end
      rbc_pkg::ST_SWEEP: begin
        mem_wr.en = 1'b1;
      end
      rbc_pkg::ST_LOOK1: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = x_q[rbc_pkg::ENTRY_W-1:0];
      end
      rbc_pkg::ST_LOOK2: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = rbc_pkg::entry_t'(rd_data + keys[vidx]);
      end
      rbc_pkg::ST_LOOK3: begin
        fire = !code_valid || code_ready;
      end
      default: begin
      end
    endcase
  end

  // distance search: first hit, then the next hit after it
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trk_next[k] = trk[k];
      if (sweep_entry == rbc_pkg::entry_t'(k) ||
          sweep_entry == rbc_pkg::entry_t'(rbc_pkg::LAST_ENTRY - rbc_pkg::entry_t'(k))) begin
        if (!trk[k].found) begin
          trk_next[k].found = 1'b1;
          trk_next[k].first = cnt;
        end else if (!trk[k].done) begin
          trk_next[k].done = 1'b1;
          trk_next[k].gap  = rbc_pkg::tctr_t'(cnt - trk[k].first);
        end
      end
    end
  end

  // ripple carry rotor steps
  always_comb begin
    vctr_next[0] = rbc_pkg::entry_t'(vctr[0] + 1'b1);
    vctr_next[1] = vctr[1];
    vctr_next[2] = vctr[2];
    if (vctr[0] == rbc_pkg::ENTRY_MAX) begin
      vctr_next[1] = rbc_pkg::entry_t'(vctr[1] + 1'b1);
      if (vctr[1] == rbc_pkg::ENTRY_MAX) begin
        vctr_next[2] = rbc_pkg::entry_t'(vctr[2] + 1'b1);
      end
    end
    tctr_next[0] = rbc_pkg::tctr_t'(tctr[0] + 1'b1);
    tctr_next[1] = tctr[1];
    tctr_next[2] = tctr[2];
    if (tctr[0] == rbc_pkg::TYPE_MAX) begin
      tctr_next[1] = rbc_pkg::tctr_t'(tctr[1] + 1'b1);
      if (tctr[1] == rbc_pkg::TYPE_MAX) begin
        tctr_next[2] = rbc_pkg::tctr_t'(tctr[2] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rbc_pkg::ST_IDLE;
      cnt        <= '0;
      code_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        trk[k]  <= '0;
        vctr[k] <= '0;
        tctr[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (byte_valid && byte_ready) begin
        x_q <= data_in;
        cnt <= '0;
        for (int k = 0; k < 3; k++) begin
          trk[k] <= '0;
        end
      end
      if (state == rbc_pkg::ST_SWEEP) begin
        cnt <= rbc_pkg::entry_t'(cnt + 1'b1);
        for (int k = 0; k < 3; k++) begin
          trk[k] <= trk_next[k];
        end
        if (cnt == rbc_pkg::LAST_ENTRY) begin
          for (int k = 0; k < 3; k++) begin
            vctr[k] <= '0;
            tctr[k] <= trk_next[k].gap;
          end
        end
      end
      if (fire) begin
        code_valid <= 1'b1;
        data_out   <= {rbc_pkg::tctr_t'(tidx + x_q[rbc_pkg::BYTE_W-1:rbc_pkg::ENTRY_W]),
                       rd_data};
        for (int k = 0; k < 3; k++) begin
          vctr[k] <= vctr_next[k];
          tctr[k] <= tctr_next[k];
        end
      end else if (code_valid && code_ready) begin
        code_valid <= 1'b0;
      end
    end
  end

  rbc_swap_mem u_swap_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/rbc_checker.sv -----
// rbc_assertions: port-level assertions for rotor_byte_cipher
// bound to the top level below; depends on rbc_pkg for widths
module rbc_assertions (
  input logic                       clk,
  input logic                       rst,
  input logic                       byte_valid,
  input logic                       byte_ready,
  input logic                       restart,
  input logic                       code_valid,
  input logic                       code_ready,
  input logic [rbc_pkg::BYTE_W-1:0] data_out
);

  // a waiting result stays put
  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(data_out))
    else $error("result dropped or changed while stalled");

  // one item at a time: no new accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready |=> !byte_ready)
    else $error("input taken while an item is in work");

  // two memory reads stand between accept and result
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready |=> !$rose(code_valid))
    else $error("result appeared too early");

  // table rebuild: the input is still closed in the last cycle of the sweep
  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && restart |-> ##32 !byte_ready)
    else $error("restart sweep ended early");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !code_valid)
    else $error("result pending after reset");

endmodule

bind rotor_byte_cipher rbc_assertions u_rbc_assertions (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .restart    (restart),
  .code_valid (code_valid),
  .code_ready (code_ready),
  .data_out   (data_out)
);

// ----- test/rbc_checker.sv -----
// rbc_checker: watches the cfg, byte and code channels of rotor_byte_cipher,
// predicts each encoded byte and compares it with what the block returns
// depends on rbc_pkg
module rbc_checker
  import rbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 byte_valid,
  input  logic                 byte_ready,
  input  logic                 restart,
  input  logic [BYTE_W-1:0]    data_in,
  input  logic                 code_valid,
  input  logic                 code_ready,
  input  logic [BYTE_W-1:0]    data_out,
  output int                   errors,
  output int                   pending
);

  key_t              live_key;
  entry_t            swap_tab [KEY_N];
  entry_t            vc_lo, vc_mid, vc_hi;
  tctr_t             tc_lo, tc_mid, tc_hi;
  logic [BYTE_W-1:0] code_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // gap, mod 8, of the first two key positions holding a or b; 0 if fewer than two
  function automatic tctr_t pair_gap(key_t k, entry_t a, entry_t b);
    int first = -1;
    for (int i = 0; i < KEY_N; i++) begin
      if (k[i] == a || k[i] == b) begin
        if (first < 0) first = i;
        else return tctr_t'(i - first);
      end
    end
    return '0;
  endfunction

  task automatic encode_byte(input logic rs, input logic [BYTE_W-1:0] din);
    entry_t v, lo;
    tctr_t  t, hi;
    if (rs) begin
      // later writes win when the key repeats values
      for (int i = 0; i < KEY_N; i++) swap_tab[live_key[i]] = live_key[KEY_N-1-i];
      {vc_hi, vc_mid, vc_lo} = '0;
      tc_lo  = pair_gap(live_key, entry_t'(0), LAST_ENTRY);
      tc_mid = pair_gap(live_key, entry_t'(1), LAST_ENTRY - entry_t'(1));
      tc_hi  = pair_gap(live_key, entry_t'(2), LAST_ENTRY - entry_t'(2));
    end
    v  = vc_lo + vc_mid + vc_hi;
    t  = tc_lo + tc_mid + tc_hi;
    lo = swap_tab[din[ENTRY_W-1:0]];
    lo = swap_tab[entry_t'(lo + live_key[v])];
    hi = t + din[BYTE_W-1:ENTRY_W];
    code_q.insert(code_q.size(), {hi, lo});
    // rotor sizes are powers of two, so the ripple is a plain increment
    {vc_hi, vc_mid, vc_lo} = {vc_hi, vc_mid, vc_lo} + 1'b1;
    {tc_hi, tc_mid, tc_lo} = {tc_hi, tc_mid, tc_lo} + 1'b1;
  endtask

  task automatic flag(input string what, input logic [BYTE_W-1:0] want);
    if (errors < 10)
      $display("%0t: %s: expected %02h got %02h", $realtime, what, want, data_out);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    logic [BYTE_W-1:0] want;
    if (rst) begin
      live_key = '0;
      foreach (swap_tab[i]) swap_tab[i] = entry_t'(i);
      {vc_hi, vc_mid, vc_lo} = '0;
      {tc_hi, tc_mid, tc_lo} = '0;
      code_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0: live_key[11:0]  = cfg_data;
          REG_KEY1: live_key[23:12] = cfg_data;
          REG_KEY2: live_key[31:24] = cfg_data[PART2_W-1:0];
          default: ;
        endcase
      end
      if (code_valid && code_ready) begin
        if (code_q.size() == 0) begin
          flag("unexpected code item", 'x);
        end else begin
          want = code_q.pop_front();
          if (data_out !== want) flag("data_out mismatch", want);
        end
      end
      if (byte_valid && byte_ready) encode_byte(restart, data_in);
    end
    pending = code_q.size();
  end

endmodule

// ----- test/rotor_byte_cipher_tb.sv -----
// rotor_byte_cipher_tb: drives keys and byte items into rotor_byte_cipher under
// varied idle and stall patterns; rbc_checker predicts and compares the results
// depends on rbc_pkg, rotor_byte_cipher and rbc_checker
module rotor_byte_cipher_tb;
  import rbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned LIMIT     = 500_000;
  localparam int unsigned SETTLE    = 48;
  localparam int unsigned HOLD_LEN  = 300;

  typedef enum int unsigned {
    K_ZERO, K_ONES, K_IDENT, K_REVERSE, K_PERM, K_RANDOM, K_PARTNERS, K_LONE
  } key_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  logic                 restart = 1'b0;
  logic [BYTE_W-1:0]    data_in = '0;
  logic                 code_valid;
  logic                 code_ready = 1'b0;
  logic [BYTE_W-1:0]    data_out;
  int                   errors;
  int                   pending;

  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  logic        hold_go    = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned cycles     = 0;
  int unsigned n_items    = 0;
  int unsigned n_restarts = 0;
  int unsigned n_keys     = 0;

  rotor_byte_cipher uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .byte_valid, .byte_ready, .restart, .data_in,
    .code_valid, .code_ready, .data_out
  );

  rbc_checker chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_LEN;
      code_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      code_ready <= 1'b0;
    end else begin
      code_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic entry_t pick_special();
    int unsigned s = $urandom_range(5);
    return entry_t'(s < 3 ? s : 26 + s);
  endfunction

  function automatic key_t make_key(key_kind_t kind);
    key_t        k;
    entry_t      t;
    int unsigned j;
    k = '0;
    case (kind)
      K_ONES:    k = '1;
      K_IDENT:   for (int i = 0; i < KEY_N; i++) k[i] = entry_t'(i);
      K_REVERSE: for (int i = 0; i < KEY_N; i++) k[i] = LAST_ENTRY - entry_t'(i);
      K_PERM: begin
        for (int i = 0; i < KEY_N; i++) k[i] = entry_t'(i);
        for (int i = KEY_N - 1; i > 0; i--) begin
          j = $urandom_range(i);
          t = k[i];
          k[i] = k[j];
          k[j] = t;
        end
      end
      K_RANDOM:  for (int i = 0; i < KEY_N; i++) k[i] = entry_t'($urandom);
      K_PARTNERS: begin
        for (int i = 0; i < KEY_N; i++)
          k[i] = ($urandom_range(99) < 25) ? pick_special() : entry_t'($urandom_range(28, 3));
      end
      K_LONE: begin
        // at most two distance partners, often a single one
        for (int i = 0; i < KEY_N; i++) k[i] = entry_t'($urandom_range(28, 3));
        k[$urandom_range(KEY_N - 1)] = pick_special();
        if ($urandom_range(1)) k[$urandom_range(KEY_N - 1)] = pick_special();
      end
      default: ;
    endcase
    return k;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // part2 carries junk from bit 40 up and the unused index gets junk too
  task automatic load_key(input key_t k);
    write_reg(REG_KEY0, k[11:0]);
    write_reg(REG_KEY1, k[23:12]);
    write_reg(REG_KEY2, {CFG_W'($urandom) << PART2_W} | CFG_W'(k[31:24]));
    write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    n_keys++;
  endtask

  task automatic set_mode(input int unsigned m);
    case (m % 4)
      0: begin send_idle = 0;  recv_stall <= 0;  end
      1: begin send_idle = 62; recv_stall <= 0;  end
      2: begin send_idle = 0;  recv_stall <= 62; end
      default: begin send_idle = 23; recv_stall <= 23; end
    endcase
  endtask

  task automatic send_byte(input logic rs, input logic [BYTE_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    restart    <= rs;
    data_in    <= d;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    n_items++;
    if (rs) n_restarts++;
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_mode(0);
    @(posedge clk);

    // encoding with the reset table and zero key, then restart on a degenerate key
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h1F);
    send_byte(1'b0, 8'hE0);
    send_byte(1'b1, 8'h5A);
    send_byte(1'b0, 8'h00);

    wait_idle();
    load_key(make_key(K_IDENT));
    send_byte(1'b1, 8'hA5);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h80);

    wait_idle();
    load_key(make_key(K_ONES));
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h7F);

    // live key change with no restart: only the key lookup sees it
    wait_idle();
    write_reg(REG_KEY0, CFG_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    send_byte(1'b0, 8'h01);
    send_byte(1'b0, 8'hFE);
    send_byte(1'b0, 8'h3C);
    send_byte(1'b1, 8'hC3);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      load_key(make_key(key_kind_t'(ph < 8 ? ph : $urandom_range(7))));
      set_mode(ph);
      n = $urandom_range(40, 20);
      for (int j = 0; j < n; j++)
        send_byte((j == 0 && ph % 5 != 4) || $urandom_range(99) < 4, BYTE_W'($urandom));
    end

    // long hold-off on the result side while items keep coming
    wait_idle();
    load_key(make_key(K_PERM));
    set_mode(0);
    hold_go <= 1'b1;
    for (int j = 0; j < 40; j++) send_byte(j == 0, BYTE_W'($urandom));

    // long run without restart so the rotor carries ripple through
    wait_idle();
    load_key(make_key(K_PARTNERS));
    set_mode(3);
    for (int j = 0; j < 700; j++) send_byte(j == 0, BYTE_W'($urandom));

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d byte items (%0d with restart) over %0d key settings",
             n_items, n_restarts, n_keys);
    $display("idle modes: none, sender gaps, receiver stalls, both; one long hold-off");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results never returned", errors, pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rbc_pkg.sv
rtl/rbc_swap_mem.sv
rtl/rotor_byte_cipher.sv
rtl/rbc_checker.sv
test/rbc_checker.sv
test/rotor_byte_cipher_tb.sv
